/* rtl/delta_list_task_scheduler_top_defines.svh */
// assertion macros for the scheduler rtl
`ifndef DELTA_LIST_TASK_SCHEDULER_TOP_DEFINES_SVH
`define DELTA_LIST_TASK_SCHEDULER_TOP_DEFINES_SVH

// checked on every edge out of reset
`define DLTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define DLTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/dlts_pkg.sv */
package dlts_pkg;

  localparam int DLY_W     = 16;
  localparam int RATE_W    = 20;
  localparam int TICK_W    = 16;
  localparam int ID_W      = 8;
  localparam int PROD_W    = DLY_W + RATE_W;
  localparam int REM_W     = 10;
  localparam int DIGIT_W   = 4;
  localparam int DIV_STEPS = PROD_W / DIGIT_W;
  localparam int STEP_W    = 4;
  localparam int PEND_W    = 5;

  localparam logic [REM_W:0]      MS_PER_S  = 11'd1000;
  localparam logic [STEP_W-1:0]   DIV_LAST  = STEP_W'(DIV_STEPS - 1);
  localparam logic [RATE_W-1:0]   RATE_RST  = 20'd1000;

  typedef enum logic [1:0] {
    FN_TICK = 2'd0,
    FN_ADD  = 2'd1,
    FN_DISP = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_MUL,
    CV_DIV
  } cvt_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_DISP,
    S_CONV,
    S_WRD,
    S_WALK,
    S_NEW,
    S_PREV,
    S_CUR
  } sched_state_t;

  typedef struct packed {
    logic              done;
    logic [TICK_W-1:0] ticks;
  } cvt_out_t;

endpackage

/* rtl/dlts_cvt.sv */
// ms to ticks: one multiply, then long division by 1000, four quotient bits a cycle
module dlts_cvt import dlts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [DLY_W-1:0]  delay_ms,
  input  logic [RATE_W-1:0] rate_hz,
  output cvt_out_t          res
);

  cvt_state_t          state_r, state_nxt;
  logic [DLY_W-1:0]    op_r;
  logic [PROD_W-1:0]   prod_r;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [TICK_W-1:0]   quo_r, quo_nxt;
  logic [STEP_W-1:0]   cnt_r;
  logic                done_r;
  logic                ld_op, ld_prod, div_en, last;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CV_IDLE: if (go) state_nxt = CV_MUL;
      CV_MUL:  state_nxt = CV_DIV;
      CV_DIV:  if (cnt_r == DIV_LAST) state_nxt = CV_IDLE;
      default: state_nxt = CV_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ld_op   = (state_r == CV_IDLE) && go;
    ld_prod = (state_r == CV_MUL);
    div_en  = (state_r == CV_DIV);
    last    = div_en && (cnt_r == DIV_LAST);
  end

  // one digit of restoring division
  always_comb begin
    logic [REM_W:0] t;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int k = 0; k < DIGIT_W; k++) begin
      t = {rem_nxt, prod_r[PROD_W-1-k]};
      if (t >= MS_PER_S) begin
        t       = t - MS_PER_S;
        quo_nxt = {quo_nxt[TICK_W-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_nxt[TICK_W-2:0], 1'b0};
      end
      rem_nxt = t[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_op) op_r <= delay_ms;
    if (ld_prod) begin
      prod_r <= PROD_W'(op_r) * PROD_W'(rate_hz);
      rem_r  <= '0;
      quo_r  <= '0;
      cnt_r  <= '0;
    end else if (div_en) begin
      prod_r <= prod_r << DIGIT_W;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      cnt_r  <= cnt_r + STEP_W'(1);
    end
  end

  assign res.done  = done_r;
  assign res.ticks = quo_r;

endmodule

/* rtl/delta_list_task_scheduler_top.sv */
// channel  | ports                                         | handshake
// ---------+-----------------------------------------------+---------------------------
// command  | in_func in_task_id in_delay_ms in_period_ms   | start, taken when !busy
// result   | out_done_res out_fired_task out_queue_full    | out_strobe, one cycle
//          | out_pending                                   |
// config   | cfg_timer_rate_hz                             | cfg_valid / cfg_ready
//
// tick: result registered out of S_TICK. dispatch without re-add: out of S_DISP.
// add: S_CONV, S_WRD, S_WALK, S_NEW, then S_PREV and/or S_CUR; the ms to ticks divider,
//   the one-entry-a-cycle walk and up to two link writes set its length, and the
//   free-slot scan (one slot a cycle) can hold the new-slot write in S_NEW.
// full-table add and unused codes answer on the cycle after start; re-add: add path.
// reset is synchronous; the slot memory needs no clearing pass.
// busy stays high for the whole operation; the result side cannot stall.
`include "delta_list_task_scheduler_top_defines.svh"

module delta_list_task_scheduler_top import dlts_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // command word
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_func,
  input  logic [ID_W-1:0]     in_task_id,
  input  logic [DLY_W-1:0]    in_delay_ms,
  input  logic [DLY_W-1:0]    in_period_ms,
  // result word
  output logic                out_strobe,
  output logic                out_done_res,
  output logic [ID_W-1:0]     out_fired_task,
  output logic                out_queue_full,
  output logic [PEND_W-1:0]   out_pending,
  // config word
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [RATE_W-1:0]   cfg_timer_rate_hz
);

  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TASKS);

  // one slot of the list
  typedef struct packed {
    logic [ID_W-1:0]   tid;
    logic [DLY_W-1:0]  period;
    logic [TICK_W-1:0] delta;
    logic [SW-1:0]     link;
  } entry_t;

  // slot memory, synchronous read
  entry_t              slot_mem [MAX_TASKS];
  entry_t              rd_data_r;
  logic [SW-1:0]       rd_addr;
  logic                wr_en;
  logic [SW-1:0]       wr_addr;
  entry_t              wr_data;

  sched_state_t        state_r, state_nxt;
  logic [RATE_W-1:0]   rate_r;
  logic [SW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [MAX_TASKS-1:0] used_r, used_nxt;

  // operand and walk registers
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [DLY_W-1:0]    per_r, per_nxt;
  logic [ID_W-1:0]     fired_r, fired_nxt;
  logic [TICK_W-1:0]   rem_r, rem_nxt;
  logic [SW-1:0]       cur_r, cur_nxt;
  logic [SW-1:0]       prev_r, prev_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  entry_t              cur_word_r, cur_word_nxt;
  entry_t              prev_word_r, prev_word_nxt;
  logic                at_head_r, at_head_nxt;
  logic                at_end_r, at_end_nxt;

  // free slot search
  logic [SW-1:0]       scan_idx_r, scan_idx_nxt;
  logic [SW-1:0]       fresh_r, fresh_nxt;
  logic                found_r, found_nxt;
  logic                scan_en;

  // result word
  logic                out_strobe_r;
  logic                out_done_r;
  logic [ID_W-1:0]     out_fired_r;
  logic                out_full_r;
  logic [PEND_W-1:0]   out_pend_r;
  logic                fin, fin_done;
  logic [ID_W-1:0]     fin_fired;

  logic                accept;
  func_t               func;
  logic                walk_go;
  logic                head_due;
  logic                cvt_go;
  logic [DLY_W-1:0]    cvt_delay;
  cvt_out_t            cvt_res;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign func      = func_t'(in_func);
  assign cfg_ready = 1'b1;

  // head entry is in rd_data_r during S_TICK and S_DISP
  assign head_due = (count_r != '0) && (rd_data_r.delta == '0);
  // keep walking while entries remain and the remaining delay covers this delta
  assign walk_go  = (i_r < count_r) && (rem_r >= rd_data_r.delta);

  dlts_cvt u_cvt (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cvt_go),
    .delay_ms (cvt_delay),
    .rate_hz  (rate_r),
    .res      (cvt_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (func)
            FN_TICK: state_nxt = S_TICK;
            FN_ADD:  state_nxt = (count_r >= MAX_CNT) ? S_IDLE : S_CONV;
            FN_DISP: state_nxt = S_DISP;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_TICK: state_nxt = S_IDLE;
      S_DISP: state_nxt = (head_due && rd_data_r.period != '0) ? S_CONV : S_IDLE;
      S_CONV: if (cvt_res.done) state_nxt = S_WRD;
      S_WRD:  state_nxt = S_WALK;
      S_WALK: if (!walk_go) state_nxt = S_NEW;
      S_NEW: begin
        if (found_r) begin
          if (!at_head_r)     state_nxt = S_PREV;
          else if (!at_end_r) state_nxt = S_CUR;
          else                state_nxt = S_IDLE;
        end
      end
      S_PREV: state_nxt = at_end_r ? S_IDLE : S_CUR;
      S_CUR:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    rd_addr       = head_r;
    wr_en         = 1'b0;
    wr_addr       = head_r;
    wr_data       = rd_data_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    used_nxt      = used_r;
    id_nxt        = id_r;
    per_nxt       = per_r;
    fired_nxt     = fired_r;
    rem_nxt       = rem_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    i_nxt         = i_r;
    cur_word_nxt  = cur_word_r;
    prev_word_nxt = prev_word_r;
    at_head_nxt   = at_head_r;
    at_end_nxt    = at_end_r;
    cvt_go        = 1'b0;
    cvt_delay     = in_delay_ms;
    fin           = 1'b0;
    fin_done      = 1'b0;
    fin_fired     = '0;

    case (state_r)
      S_IDLE: begin
        // head read goes out every idle cycle, ready for tick or dispatch
        if (accept) begin
          id_nxt    = in_task_id;
          per_nxt   = in_period_ms;
          fired_nxt = '0;
          case (func)
            FN_TICK: ;
            FN_DISP: ;
            FN_ADD: begin
              if (count_r >= MAX_CNT) fin = 1'b1;
              else                    cvt_go = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_TICK: begin
        fin = 1'b1;
        if (count_r != '0 && rd_data_r.delta != '0) begin
          wr_en         = 1'b1;
          wr_data.delta = rd_data_r.delta - TICK_W'(1);
        end
      end
      S_DISP: begin
        if (head_due) begin
          head_nxt         = (count_r > CW'(1)) ? rd_data_r.link : '0;
          used_nxt[head_r] = 1'b0;
          count_nxt        = count_r - CW'(1);
          fired_nxt        = rd_data_r.tid;
          if (rd_data_r.period != '0) begin
            // periodic task goes back in through the add path
            id_nxt    = rd_data_r.tid;
            per_nxt   = rd_data_r.period;
            cvt_go    = 1'b1;
            cvt_delay = rd_data_r.period;
          end else begin
            fin       = 1'b1;
            fin_done  = 1'b1;
            fin_fired = rd_data_r.tid;
          end
        end else begin
          fin = 1'b1;
        end
      end
      S_CONV: begin
        if (cvt_res.done) rem_nxt = cvt_res.ticks;
      end
      S_WRD: begin
        cur_nxt = head_r;
        i_nxt   = '0;
      end
      S_WALK: begin
        if (walk_go) begin
          rem_nxt       = rem_r - rd_data_r.delta;
          prev_nxt      = cur_r;
          prev_word_nxt = rd_data_r;
          cur_nxt       = rd_data_r.link;
          i_nxt         = i_r + CW'(1);
          rd_addr       = rd_data_r.link;
        end else begin
          cur_word_nxt = rd_data_r;
          at_head_nxt  = (i_r == '0);
          at_end_nxt   = !(i_r < count_r);
        end
      end
      S_NEW: begin
        if (found_r) begin
          wr_en            = 1'b1;
          wr_addr          = fresh_r;
          wr_data.tid      = id_r;
          wr_data.period   = per_r;
          wr_data.delta    = rem_r;
          wr_data.link     = at_end_r ? '0 : cur_r;
          used_nxt[fresh_r] = 1'b1;
          count_nxt        = count_r + CW'(1);
          if (at_head_r) head_nxt = fresh_r;
          if (at_head_r && at_end_r) begin
            fin       = 1'b1;
            fin_done  = 1'b1;
            fin_fired = fired_r;
          end
        end
      end
      S_PREV: begin
        // predecessor now points at the new slot
        wr_en        = 1'b1;
        wr_addr      = prev_r;
        wr_data      = prev_word_r;
        wr_data.link = fresh_r;
        if (at_end_r) begin
          fin       = 1'b1;
          fin_done  = 1'b1;
          fin_fired = fired_r;
        end
      end
      S_CUR: begin
        // successor keeps its absolute time
        wr_en         = 1'b1;
        wr_addr       = cur_r;
        wr_data       = cur_word_r;
        wr_data.delta = cur_word_r.delta - rem_r;
        fin           = 1'b1;
        fin_done      = 1'b1;
        fin_fired     = fired_r;
      end
      default: ;
    endcase
  end

  // lowest free slot, one slot a cycle, overlapped with the conversion
  assign scan_en = (state_r inside {S_CONV, S_WRD, S_WALK, S_NEW});

  always_comb begin
    scan_idx_nxt = scan_idx_r;
    fresh_nxt    = fresh_r;
    found_nxt    = found_r;
    if (cvt_go) begin
      scan_idx_nxt = '0;
      found_nxt    = 1'b0;
    end else if (scan_en && !found_r) begin
      if (!used_r[scan_idx_r]) begin
        found_nxt = 1'b1;
        fresh_nxt = scan_idx_r;
      end else begin
        scan_idx_nxt = scan_idx_r + SW'(1);
      end
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) slot_mem[wr_addr] <= wr_data;
    rd_data_r <= slot_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rate_r       <= RATE_RST;
      head_r       <= '0;
      count_r      <= '0;
      used_r       <= '0;
      found_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      used_r       <= used_nxt;
      found_r      <= found_nxt;
      out_strobe_r <= fin;
      if (cfg_valid && cfg_ready) rate_r <= cfg_timer_rate_hz;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    per_r       <= per_nxt;
    fired_r     <= fired_nxt;
    rem_r       <= rem_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    i_r         <= i_nxt;
    cur_word_r  <= cur_word_nxt;
    prev_word_r <= prev_word_nxt;
    at_head_r   <= at_head_nxt;
    at_end_r    <= at_end_nxt;
    scan_idx_r  <= scan_idx_nxt;
    fresh_r     <= fresh_nxt;
    if (fin) begin
      out_done_r  <= fin_done;
      out_fired_r <= fin_fired;
      out_full_r  <= (count_nxt >= MAX_CNT);
      out_pend_r  <= PEND_W'(count_nxt);
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_done_res   = out_done_r;
  assign out_fired_task = out_fired_r;
  assign out_queue_full = out_full_r;
  assign out_pending    = out_pend_r;

  // checks
  `DLTS_ASSERT(a_cnt_range, count_r <= MAX_CNT, "task count above table size")
  `DLTS_ASSERT(a_used_cnt, $countones(used_r) == int'(count_r), "used slots differ from count")
  `DLTS_ASSERT(a_new_free, (state_r == S_NEW && found_r) |-> !used_r[fresh_r], "new slot in use")
  `DLTS_ASSERT(a_cvt_wait, cvt_res.done |-> (state_r == S_CONV), "conversion done while not waiting")
  `DLTS_ASSERT(a_walk_bound, (state_r == S_WALK) |-> (i_r <= count_r), "walk ran past list end")

endmodule
